// ===== rtl/kdfe_pkg.sv =====
// Shared types and constants for the keyed decimal field extractor.
// Used by every module of the block; depends on nothing.
`default_nettype none
package kdfe_pkg;

	localparam int KEY_MAX_BYTES_DEF = 8;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_INDEX_W = 2;
	localparam int VALUE_W = 32;

	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_BYTES = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LENGTH = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_FALLBACK = 2'd2;

	localparam logic [63:0] KEY_BYTES_RST = 64'd97;
	localparam logic [3:0] KEY_LENGTH_RST = 4'd1;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;

	typedef struct packed {
		logic [7:0] data_byte;
		logic has_byte;
		logic last_byte;
	} item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] field_value;
		logic found;
	} result_t;

endpackage
`default_nettype wire

// ===== rtl/kdfe_if.sv =====
// Valid/ready channel interfaces for the input bytes and the results.
// Depends on kdfe_pkg for the payload widths.
`default_nettype none
interface kdfe_item_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;
	logic has_byte;
	logic last_byte;
	modport source (output valid, data_byte, has_byte, last_byte, input ready);
	modport sink (input valid, data_byte, has_byte, last_byte, output ready);
endinterface

interface kdfe_result_if import kdfe_pkg::*;;
	logic valid;
	logic ready;
	logic signed [VALUE_W-1:0] field_value;
	logic found;
	modport source (output valid, field_value, found, input ready);
	modport sink (input valid, field_value, found, output ready);
endinterface
`default_nettype wire

// ===== rtl/keyed_decimal_field_extractor.sv =====
// Top level: input register, scan stage, configuration registers and result register.
// Depends on kdfe_pkg, kdfe_if, kdfe_cfg and kdfe_scan.
//
//   channel   dir   payload                                   note
//   item      in    data_byte[7:0], has_byte, last_byte       one beat per byte
//   result    out   field_value[31:0] signed, found           one beat per last item
//   cfg_*     in    cfg_we, cfg_index[1:0], cfg_data[63:0]    write only
//
// One byte beat is accepted per cycle unless a last item waits in the input register for
// a full result register; a byte that is not last is stepped in the cycle after. A last
// item's result is registered in the result register when its scan step runs. While a
// result waits, byte beats that are not last keep flowing through. All control state
// clears on arst_n; configuration returns to key "a", length 1, fallback 0.
`default_nettype none
module keyed_decimal_field_extractor import kdfe_pkg::*; #(
	parameter int KEY_MAX_BYTES = KEY_MAX_BYTES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	kdfe_item_if.sink item,
	kdfe_result_if.source result,
	input wire logic cfg_we,
	input wire logic [CFG_INDEX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic [KEY_MAX_BYTES*8-1:0] key_q;
	logic [3:0] key_len_q;
	logic signed [VALUE_W-1:0] fallback_q;

	logic s1_valid_q;
	item_t item_s1;
	logic out_valid_q;
	result_t out_q;
	result_t step_res;
	logic out_free, s1_adv;

	assign out_free = !out_valid_q || result.ready;
	assign s1_adv = s1_valid_q && (!item_s1.last_byte || out_free);
	assign item.ready = !s1_valid_q || s1_adv;

	kdfe_cfg #(.KEY_MAX_BYTES(KEY_MAX_BYTES)) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.key_q(key_q),
		.key_len_q(key_len_q),
		.fallback_q(fallback_q)
	);

	kdfe_scan #(.KEY_MAX_BYTES(KEY_MAX_BYTES)) u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.step_en(s1_adv),
		.item_s1(item_s1),
		.key_q(key_q),
		.key_len_q(key_len_q),
		.fallback_q(fallback_q),
		.result(step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (item.valid && item.ready) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.data_byte <= item.data_byte;
			item_s1.has_byte <= item.has_byte;
			item_s1.last_byte <= item.last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && item_s1.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && item_s1.last_byte) out_q <= step_res;
	end

	assign result.valid = out_valid_q;
	assign result.field_value = out_q.field_value;
	assign result.found = out_q.found;

endmodule
`default_nettype wire

// ===== rtl/kdfe_cfg.sv =====
// Configuration registers: key characters, key length and fallback value.
// Depends on kdfe_pkg for register indexes and reset values.
`default_nettype none
module kdfe_cfg import kdfe_pkg::*; #(
	parameter int KEY_MAX_BYTES = KEY_MAX_BYTES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [CFG_INDEX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data,
	output logic [KEY_MAX_BYTES*8-1:0] key_q,
	output logic [3:0] key_len_q,
	output logic signed [VALUE_W-1:0] fallback_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= KEY_BYTES_RST[KEY_MAX_BYTES*8-1:0];
			key_len_q <= KEY_LENGTH_RST;
			fallback_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KEY_BYTES: key_q <= cfg_data[KEY_MAX_BYTES*8-1:0];
				CFG_KEY_LENGTH: key_len_q <= cfg_data[3:0];
				CFG_FALLBACK: fallback_q <= cfg_data[VALUE_W-1:0];
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/kdfe_scan.sv =====
// Scan state machine: key match, colon and blank skip, sign and digit run.
// Depends on kdfe_pkg; takes one registered item per enabled cycle.
`default_nettype none
module kdfe_scan import kdfe_pkg::*; #(
	parameter int KEY_MAX_BYTES = KEY_MAX_BYTES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic step_en,
	input wire item_t item_s1,
	input wire logic [KEY_MAX_BYTES*8-1:0] key_q,
	input wire logic [3:0] key_len_q,
	input wire logic signed [VALUE_W-1:0] fallback_q,
	output result_t result
);

	localparam logic [2:0] PH_SEARCH = 3'd0;
	localparam logic [2:0] PH_MATCH = 3'd1;
	localparam logic [2:0] PH_COLON = 3'd2;
	localparam logic [2:0] PH_SPACE = 3'd3;
	localparam logic [2:0] PH_DIGITS = 3'd4;
	localparam logic [2:0] PH_DONE = 3'd5;
	localparam logic [3:0] MAX_LEN = 4'(KEY_MAX_BYTES);

	logic [2:0] phase_q, phase_n;
	logic [3:0] match_idx_q, match_idx_n;
	logic [VALUE_W-1:0] acc_q, acc_n;
	logic neg_q, neg_n, seen_q, seen_n;
	logic [3:0] eff_len, idx_inc;
	logic [7:0] c, kchar;
	logic is_digit;
	logic [VALUE_W-1:0] digit, acc_x10;
	logic [2:0] quote_phase;

	assign c = item_s1.data_byte;
	assign eff_len = (key_len_q > MAX_LEN) ? MAX_LEN : key_len_q;
	assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
	assign digit = VALUE_W'(c - CH_ZERO);
	assign acc_x10 = (acc_q << 3) + (acc_q << 1);
	assign idx_inc = match_idx_q + 4'd1;
	assign quote_phase = (eff_len == 4'd0) ? PH_COLON : PH_MATCH;

	always_comb begin
		kchar = '0;
		for (int i = 0; i < KEY_MAX_BYTES; i++) begin
			if (match_idx_q == 4'(i)) kchar = key_q[i*8 +: 8];
		end
	end

	always_comb begin
		phase_n = phase_q;
		match_idx_n = match_idx_q;
		acc_n = acc_q;
		neg_n = neg_q;
		seen_n = seen_q;
		if (item_s1.has_byte) begin
			unique case (phase_q)
				PH_SEARCH: begin
					if (c == CH_QUOTE) begin
						phase_n = quote_phase;
						match_idx_n = '0;
					end
				end
				PH_MATCH: begin
					if (c == kchar) begin
						match_idx_n = idx_inc;
						if (idx_inc >= eff_len) phase_n = PH_COLON;
					end else if (c == CH_QUOTE) begin
						phase_n = quote_phase;
						match_idx_n = '0;
					end else begin
						phase_n = PH_SEARCH;
						match_idx_n = '0;
					end
				end
				PH_COLON: begin
					if (c == CH_COLON) phase_n = PH_SPACE;
				end
				PH_SPACE: begin
					if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
						phase_n = PH_SPACE;
					end else if (c == CH_MINUS) begin
						neg_n = 1'b1;
						phase_n = PH_DIGITS;
					end else if (is_digit) begin
						acc_n = digit;
						seen_n = 1'b1;
						phase_n = PH_DIGITS;
					end else begin
						phase_n = PH_DONE;
					end
				end
				PH_DIGITS: begin
					if (is_digit) begin
						acc_n = acc_x10 + digit;
						seen_n = 1'b1;
					end else begin
						phase_n = PH_DONE;
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		result.found = seen_n;
		if (seen_n) result.field_value = neg_n ? -acc_n : acc_n;
		else result.field_value = fallback_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
			match_idx_q <= '0;
			acc_q <= '0;
			neg_q <= 1'b0;
			seen_q <= 1'b0;
		end else if (step_en) begin
			if (item_s1.last_byte) begin
				phase_q <= PH_SEARCH;
				match_idx_q <= '0;
				acc_q <= '0;
				neg_q <= 1'b0;
				seen_q <= 1'b0;
			end else begin
				phase_q <= phase_n;
				match_idx_q <= match_idx_n;
				acc_q <= acc_n;
				neg_q <= neg_n;
				seen_q <= seen_n;
			end
		end
	end

endmodule
`default_nettype wire

// ===== dv/keyed_decimal_field_extractor_tb.sv =====
// Self-checking testbench for the keyed decimal field extractor: byte streams of
// quoted keys, colons, blanks and digit runs under several key settings and stalls.
// Depends on kdfe_pkg, kdfe_if and the keyed_decimal_field_extractor RTL.
`default_nettype none
module keyed_decimal_field_extractor_tb;
	import kdfe_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 6;
	localparam int HOLD_CYCLES = 200;

	typedef enum logic [2:0] {
		SEEK_QUOTE, MATCH_KEY, SEEK_COLON, SKIP_BLANKS, TAKE_DIGITS, SKIP_REST
	} scan_phase_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	kdfe_item_if byte_ch();
	kdfe_result_if field_ch();

	keyed_decimal_field_extractor uut (
		.clk(clk),
		.arst_n(arst_n),
		.item(byte_ch),
		.result(field_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	logic [63:0] key_reg;
	logic [3:0] key_len_reg;
	logic signed [31:0] fallback_reg;
	scan_phase_t phase;
	logic [3:0] match_idx;
	logic [31:0] acc;
	logic neg;
	logic seen;

	result_t parsed_fields[$];
	item_t stream_q[$];

	int mismatches = 0;
	int quiet_cycles = 0;
	int hold_request = 0;
	bit sender_idles = 1'b1;
	bit receiver_idles = 1'b1;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic logic [3:0] used_key_len();
		if (key_len_reg > KEY_MAX_BYTES_DEF) begin
			return 4'(KEY_MAX_BYTES_DEF);
		end
		return key_len_reg;
	endfunction

	function automatic void clear_scan();
		phase = SEEK_QUOTE;
		match_idx = '0;
		acc = '0;
		neg = 1'b0;
		seen = 1'b0;
	endfunction

	function automatic void open_key_match();
		if (used_key_len() == 4'd0) begin
			phase = SEEK_COLON;
		end else begin
			phase = MATCH_KEY;
			match_idx = '0;
		end
	endfunction

	function automatic void advance_scan(logic [7:0] c);
		logic [7:0] kc;
		logic is_digit;
		kc = key_reg[match_idx[2:0]*8 +: 8];
		is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
		case (phase)
			SEEK_QUOTE: begin
				if (c == CH_QUOTE) begin
					open_key_match();
				end
			end
			MATCH_KEY: begin
				if (c == kc) begin
					match_idx = match_idx + 4'd1;
					if (match_idx >= used_key_len()) begin
						phase = SEEK_COLON;
					end
				end else if (c == CH_QUOTE) begin
					open_key_match();
				end else begin
					phase = SEEK_QUOTE;
					match_idx = '0;
				end
			end
			SEEK_COLON: begin
				if (c == CH_COLON) begin
					phase = SKIP_BLANKS;
				end
			end
			SKIP_BLANKS: begin
				if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
					phase = SKIP_BLANKS;
				end else if (c == CH_MINUS) begin
					neg = 1'b1;
					phase = TAKE_DIGITS;
				end else if (is_digit) begin
					acc = 32'(c - CH_ZERO);
					seen = 1'b1;
					phase = TAKE_DIGITS;
				end else begin
					phase = SKIP_REST;
				end
			end
			TAKE_DIGITS: begin
				if (is_digit) begin
					acc = acc * 32'd10 + 32'(c - CH_ZERO);
					seen = 1'b1;
				end else begin
					phase = SKIP_REST;
				end
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void parse_item(item_t it);
		result_t r;
		if (it.has_byte) begin
			advance_scan(it.data_byte);
		end
		if (it.last_byte) begin
			r.found = seen;
			r.field_value = seen ? (neg ? 32'd0 - acc : acc) : fallback_reg;
			parsed_fields.push_back(r);
			clear_scan();
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && field_ch.valid && field_ch.ready) begin
			if (parsed_fields.size() == 0) begin
				if (mismatches < 10) begin
					$display("unexpected result beat: value %0d found %0b",
						field_ch.field_value, field_ch.found);
				end
				mismatches++;
			end else if (parsed_fields[0].field_value !== field_ch.field_value ||
					parsed_fields[0].found !== field_ch.found) begin
				if (mismatches < 10) begin
					$display("mismatch: expected value %0d found %0b, got value %0d found %0b",
						parsed_fields[0].field_value, parsed_fields[0].found,
						field_ch.field_value, field_ch.found);
				end
				mismatches++;
				void'(parsed_fields.pop_front());
			end else begin
				void'(parsed_fields.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_ch.valid && byte_ch.ready) || (field_ch.valid && field_ch.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("FAIL");
					$finish;
				end
			end
		end
	end

	// Result side: random stalls, plus a long hold-off on request.
	initial begin
		int n;
		field_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				n = hold_request;
				hold_request = 0;
				field_ch.ready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
				field_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 14) - 1) @(negedge clk);
			end else begin
				field_ch.ready <= 1'b1;
			end
		end
	end

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [63:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_KEY_BYTES: key_reg = val;
			CFG_KEY_LENGTH: key_len_reg = val[3:0];
			CFG_FALLBACK: fallback_reg = val[31:0];
			default: begin
			end
		endcase
	endtask

	task automatic wait_drained();
		while (parsed_fields.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_stream();
		item_t it;
		while (stream_q.size() > 0) begin
			it = stream_q.pop_front();
			@(negedge clk);
			if (sender_idles && $urandom_range(0, 7) == 0) begin
				byte_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 14)) @(negedge clk);
			end
			byte_ch.valid <= 1'b1;
			byte_ch.data_byte <= it.data_byte;
			byte_ch.has_byte <= it.has_byte;
			byte_ch.last_byte <= it.last_byte;
			do @(posedge clk); while (!byte_ch.ready);
			parse_item(it);
		end
		@(negedge clk);
		byte_ch.valid <= 1'b0;
	endtask

	function automatic void push_item(logic [7:0] c, logic has, logic last);
		item_t it;
		it.data_byte = c;
		it.has_byte = has;
		it.last_byte = last;
		stream_q.push_back(it);
	endfunction

	function automatic void push_char(logic [7:0] c, logic last);
		push_item(c, 1'b1, last);
		if (!last && $urandom_range(0, 39) == 0) begin
			push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
		end
	endfunction

	function automatic void add_text(string s, bit marker_last);
		for (int i = 0; i < s.len(); i++) begin
			push_char(s[i], !marker_last && i == s.len() - 1);
		end
		if (marker_last || s.len() == 0) begin
			push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
		end
	endfunction

	function automatic logic [7:0] noise_char();
		if ($urandom_range(0, 9) < 7) begin
			return 8'($urandom_range(32, 126));
		end
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] blank_char();
		case ($urandom_range(0, 3))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_LF;
			default: return CH_CR;
		endcase
	endfunction

	// Mostly well-formed "key": value text with random content; some noise and cut-offs.
	function automatic void add_random_buffer();
		logic [7:0] text[$];
		logic [7:0] c;
		int n;
		int klen;
		klen = int'(used_key_len());
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(0, 12)) text.push_back(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(0, 3)) text.push_back(noise_char());
			text.push_back(CH_QUOTE);
			n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, klen) : klen;
			for (int i = 0; i < n; i++) begin
				c = key_reg[i*8 +: 8];
				if ($urandom_range(0, 19) == 0) begin
					c = 8'($urandom_range(0, 255));
				end
				text.push_back(c);
			end
			repeat ($urandom_range(0, 2)) text.push_back(8'($urandom_range(97, 122)));
			if ($urandom_range(0, 1) == 1) begin
				text.push_back(CH_QUOTE);
			end
			if ($urandom_range(0, 9) != 0) begin
				text.push_back(CH_COLON);
			end
			repeat ($urandom_range(0, 3)) text.push_back(blank_char());
			if ($urandom_range(0, 3) == 0) begin
				text.push_back(CH_MINUS);
			end
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 12) : $urandom_range(0, 5);
			repeat (n) text.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
			repeat ($urandom_range(0, 3)) text.push_back(noise_char());
			if ($urandom_range(0, 7) == 0) begin
				repeat ($urandom_range(0, text.size() - 1)) void'(text.pop_back());
			end
		end
		if (text.size() == 0) begin
			push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
		end else if ($urandom_range(0, 4) == 0) begin
			foreach (text[i]) push_char(text[i], 1'b0);
			push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
		end else begin
			foreach (text[i]) push_char(text[i], i == text.size() - 1);
		end
	endfunction

	function automatic logic [63:0] pack_key(string s);
		logic [63:0] k;
		k = '0;
		for (int i = 0; i < s.len() && i < 8; i++) begin
			k[i*8 +: 8] = s[i];
		end
		return k;
	endfunction

	function automatic logic [63:0] random_letters();
		logic [63:0] k;
		for (int i = 0; i < 8; i++) begin
			k[i*8 +: 8] = 8'($urandom_range(97, 122));
		end
		return k;
	endfunction

	task automatic run_setting(logic [63:0] key, logic [3:0] len, logic [31:0] fallback,
			int n_items);
		wait_drained();
		write_reg(CFG_KEY_BYTES, key);
		write_reg(CFG_KEY_LENGTH, 64'(len));
		write_reg(CFG_FALLBACK, 64'(fallback));
		while (stream_q.size() < n_items) add_random_buffer();
		send_stream();
	endtask

	task automatic test_directed_defaults();
		add_text("", 1'b1);
		add_text("\"a:\t-9", 1'b0);
		add_text("\"\"a: 5", 1'b0);
		add_text("\"b:3", 1'b1);
		add_text("\"a:-", 1'b0);
		push_item(8'hFF, 1'b1, 1'b0);
		push_item(8'h00, 1'b0, 1'b0);
		push_item(8'h00, 1'b1, 1'b1);
		send_stream();
	endtask

	task automatic test_key_settings();
		logic [63:0] quoted_key;
		quoted_key = random_letters();
		quoted_key[15:8] = CH_QUOTE;
		run_setting(pack_key("id"), 4'd2, 32'hFFFF_FFFF, 65);
		run_setting(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h8000_0000, 65);
		run_setting(64'd0, 4'd0, 32'h7FFF_FFFF, 65);
		run_setting(random_letters(), 4'd15, $urandom, 65);
		run_setting(quoted_key, 4'd3, $urandom, 65);
		run_setting({$urandom, $urandom}, 4'($urandom_range(1, 8)), $urandom, 65);
		run_setting(pack_key("value"), 4'd5, 32'd0, 65);
	endtask

	task automatic test_output_stall();
		wait_drained();
		hold_request = HOLD_CYCLES;
		run_setting(pack_key("n"), 4'd1, $urandom, 100);
		wait_drained();
	endtask

	task automatic test_streaming();
		wait_drained();
		sender_idles = 1'b0;
		receiver_idles = 1'b0;
		run_setting(pack_key("ab"), 4'd2, $urandom, 150);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = '0;
		byte_ch.has_byte = 1'b0;
		byte_ch.last_byte = 1'b0;
		key_reg = KEY_BYTES_RST;
		key_len_reg = KEY_LENGTH_RST;
		fallback_reg = '0;
		clear_scan();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_defaults();
		test_key_settings();
		test_output_stall();
		test_streaming();

		wait_drained();
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire
